// ----- rtl/core/modular_exponentiation_signed_exp_macros.svh -----
// Assertion macros shared by the modular exponentiation RTL
`ifndef MODULAR_EXPONENTIATION_SIGNED_EXP_MACROS_SVH
`define MODULAR_EXPONENTIATION_SIGNED_EXP_MACROS_SVH
// Implication checked every clock outside reset
`define MEX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define MEX_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/core/mex_pkg.sv -----
// Package: shared constants, types and states for the modular exponentiation block
package mex_pkg;
    localparam int unsigned MOD_WIDTH_DEF = 16;
    localparam int unsigned BASE_W = 17;
    localparam int unsigned EXP_W = 17;
    localparam int unsigned RES_W = 16;
    localparam int unsigned QDEPTH = 2;

    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_EXPONENT = 1'b1;

    typedef enum logic [1:0] {
        T_CLS_NORMAL,
        T_CLS_ONE,
        T_CLS_ZERO
    } t_cls;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED,
        S_EUC_DIV,
        S_EUC_UPD,
        S_EUC_FIN,
        S_EXP_CHK,
        S_MUL,
        S_MUL_RED,
        S_SQR,
        S_SQR_RED,
        S_DONE
    } t_state;
endpackage

// ----- rtl/core/mex_front.sv -----
// Front end: classify each base and push it into a small queue
module mex_front #(
    parameter int unsigned MOD_WIDTH = mex_pkg::MOD_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [mex_pkg::BASE_W-1:0] i_base_value,
    input  logic [MOD_WIDTH-1:0]       i_modulus,
    input  logic [mex_pkg::EXP_W-1:0]  i_exponent,
    output logic                       o_q_valid,
    input  logic                       i_q_ready,
    output logic [mex_pkg::BASE_W-1:0] o_q_base,
    output mex_pkg::t_cls              o_q_cls
);
    import mex_pkg::*;
    `include "modular_exponentiation_signed_exp_macros.svh"

    logic [BASE_W-1:0] r_base [QDEPTH];
    t_cls              r_cls  [QDEPTH];
    logic              r_wp, n_wp, r_rp, n_rp;
    logic [1:0]        r_cnt, n_cnt;
    logic              push, pop;
    t_cls              cls;

    // classify against the current registers
    always_comb begin
        if (i_exponent == '0)     cls = T_CLS_ONE;
        else if (i_modulus == '0) cls = T_CLS_ZERO;
        else                      cls = T_CLS_NORMAL;
    end

    assign o_ready   = (r_cnt != 2'(QDEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_base  = r_base[r_rp];
    assign o_q_cls   = r_cls[r_rp];

    // advance pointers and count
    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // hold queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_base[r_wp] <= i_base_value;
            r_cls[r_wp]  <= cls;
        end
    end

    `MEX_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 2'(QDEPTH), "queue overflow")
    `MEX_ASSERT_NXT(a_full_hold, i_clk, i_rst_n, r_cnt == 2'(QDEPTH) && !pop, !o_ready,
        "full queue accepted")
    `MEX_ASSERT_IMP(a_empty_nopop, i_clk, i_rst_n, r_cnt == 2'd0, !o_q_valid,
        "empty queue shows valid")
endmodule

// ----- rtl/core/mex_back.sv -----
// Back end: reduction, extended Euclid and square-and-multiply sequencer
module mex_back #(
    parameter int unsigned MOD_WIDTH = mex_pkg::MOD_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    output logic                       o_q_ready,
    input  logic [mex_pkg::BASE_W-1:0] i_q_base,
    input  mex_pkg::t_cls              i_q_cls,
    input  logic [MOD_WIDTH-1:0]       i_modulus,
    input  logic [mex_pkg::EXP_W-1:0]  i_exponent,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [mex_pkg::RES_W-1:0]  o_power_result
);
    import mex_pkg::*;
    `include "modular_exponentiation_signed_exp_macros.svh"

    localparam int unsigned PW = 2 * MOD_WIDTH;
    localparam int unsigned DW = PW + 1;          // signed dividend width
    localparam int unsigned CW = $clog2(DW + 1);
    localparam int unsigned SW = MOD_WIDTH + 2;   // Bezout coefficient width

    t_state r_state, n_state;

    // shared restoring divider: remainder of |dividend| by modulus (by r_y in S_EUC_DIV), or quotient
    logic [DW-1:0]        r_num;
    logic [MOD_WIDTH:0]   r_rem;
    logic [CW-1:0]        r_cnt;
    logic                 r_neg;

    logic [MOD_WIDTH-1:0] r_base, r_res, r_y;
    logic signed [SW-1:0] r_s0, r_s1;
    logic [EXP_W-1:0]     r_mag;
    logic [RES_W-1:0]     r_out;
    logic                 r_ovalid;

    logic [MOD_WIDTH:0]   trial;
    logic                 fits;
    logic [MOD_WIDTH-1:0] divisor;
    logic signed [SW+MOD_WIDTH:0] s2;
    logic [MOD_WIDTH-1:0] rem_fix;

    assign divisor = (r_state == S_EUC_DIV) ? r_y : i_modulus;
    assign trial   = {r_rem[MOD_WIDTH-1:0], r_num[DW-1]};
    assign fits    = trial >= {1'b0, divisor};
    // remainder of a negative dividend folds up by the modulus
    assign rem_fix = (r_neg && r_rem[MOD_WIDTH-1:0] != '0)
                     ? MOD_WIDTH'(i_modulus - r_rem[MOD_WIDTH-1:0])
                     : r_rem[MOD_WIDTH-1:0];
    assign s2      = (SW+MOD_WIDTH+1)'(r_s0)
                     - $signed({1'b0, r_num[MOD_WIDTH-1:0]}) * r_s1;

    assign o_q_ready      = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid        = r_ovalid;
    assign o_power_result = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_q_valid && o_q_ready) begin
                           n_state = (i_q_cls == T_CLS_NORMAL) ? S_RED : S_DONE;
                       end
            S_RED, S_MUL_RED, S_SQR_RED:
                       if (r_cnt == CW'(DW)) begin
                           n_state = (r_state == S_RED)
                                     ? (i_exponent[EXP_W-1] ? S_EUC_DIV : S_EXP_CHK)
                                     : (r_state == S_MUL_RED ? S_SQR : S_EXP_CHK);
                       end
            S_EUC_DIV: if (r_y == '0) n_state = S_EUC_FIN;
                       else if (r_cnt == CW'(DW)) n_state = S_EUC_UPD;
            S_EUC_UPD: n_state = S_EUC_DIV;
            S_EUC_FIN: if (r_cnt == CW'(DW)) n_state = S_EXP_CHK;
            S_EXP_CHK: n_state = (r_mag == '0) ? S_DONE : (r_mag[0] ? S_MUL : S_SQR);
            S_MUL:     n_state = S_MUL_RED;
            S_SQR:     n_state = S_SQR_RED;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        // divider step, shared by all long-division states
        if (r_state == S_RED || r_state == S_MUL_RED || r_state == S_SQR_RED
            || (r_state == S_EUC_DIV && r_y != '0) || r_state == S_EUC_FIN) begin
            if (r_cnt != CW'(DW)) begin
                r_rem <= fits ? trial - {1'b0, divisor} : trial;
                r_num <= {r_num[DW-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
            end
        end
        unique case (r_state)
            S_IDLE: begin
                // hold the presented result until the next base is taken
                if (i_q_valid && o_q_ready) begin
                    r_out <= (i_q_cls == T_CLS_ONE) ? RES_W'(1) : '0;
                end
                r_res <= MOD_WIDTH'(1);
                r_mag <= i_exponent[EXP_W-1] ? EXP_W'(-i_exponent) : i_exponent;
                r_neg <= i_q_base[BASE_W-1];
                r_num <= i_q_base[BASE_W-1]
                         ? DW'(-$signed({i_q_base[BASE_W-1], i_q_base}))
                         : DW'(i_q_base);
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_RED: if (r_cnt == CW'(DW)) begin
                r_base <= rem_fix;
                r_y    <= i_modulus;
                r_s0   <= SW'(1);
                r_s1   <= '0;
                r_num  <= DW'(rem_fix);
                r_rem  <= '0;
                r_cnt  <= '0;
                r_neg  <= 1'b0;
            end
            S_EUC_DIV: if (r_y == '0) begin
                // reduce s0 modulo n
                r_neg <= r_s0[SW-1];
                r_num <= r_s0[SW-1] ? DW'(-r_s0) : DW'(r_s0);
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_EUC_UPD: begin
                // quotient in r_num, remainder in r_rem; old divisor is the next dividend
                r_y   <= r_rem[MOD_WIDTH-1:0];
                r_s0  <= r_s1;
                r_s1  <= SW'(s2);
                r_num <= DW'(r_y);
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_EUC_FIN: if (r_cnt == CW'(DW)) r_base <= rem_fix;
            S_MUL_RED: if (r_cnt == CW'(DW)) r_res <= r_rem[MOD_WIDTH-1:0];
            S_SQR_RED: if (r_cnt == CW'(DW)) begin
                r_base <= r_rem[MOD_WIDTH-1:0];
                r_mag  <= r_mag >> 1;
            end
            S_MUL: begin
                r_num <= DW'(PW'(r_res) * PW'(r_base));
                r_rem <= '0;
                r_cnt <= '0;
                r_neg <= 1'b0;
            end
            S_SQR: begin
                r_num <= DW'(PW'(r_base) * PW'(r_base));
                r_rem <= '0;
                r_cnt <= '0;
                r_neg <= 1'b0;
            end
            S_EXP_CHK: if (r_mag == '0) r_out <= RES_W'(r_res);
            default: ;
        endcase
    end

    `MEX_ASSERT_NXT(a_done_valid, i_clk, i_rst_n, r_state == S_DONE, o_valid,
        "result not presented")
    `MEX_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_q_ready,
        "queue read while busy")
    `MEX_ASSERT_IMP(a_div_cnt, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(DW),
        "divider counter overrun")
endmodule

// ----- rtl/core/modular_exponentiation_signed_exp.sv -----
// Modular exponentiation with signed base and signed exponent. Results come
// out in input order, one per base. All long divisions run in one shared
// bit-serial divider. Taking a base reduces it modulo the modulus; a negative
// exponent adds one division per extended Euclid step and a final reduction
// of the coefficient; each exponent bit then costs a square, plus a multiply
// when the bit is set. Exponent zero or modulus zero gives the result without
// any division. The back end takes the next base only once the previous
// result has been transferred; a two-entry queue in front lets the next
// bases wait meanwhile.
module modular_exponentiation_signed_exp #(
    parameter int unsigned MOD_WIDTH = mex_pkg::MOD_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [mex_pkg::BASE_W-1:0] i_base_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [mex_pkg::RES_W-1:0]  o_power_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [mex_pkg::EXP_W-1:0]  i_cfg_data
);
    import mex_pkg::*;

    logic [MOD_WIDTH-1:0] r_modulus;
    logic [EXP_W-1:0]     r_exponent;
    logic                 q_valid, q_ready;
    logic [BASE_W-1:0]    q_base;
    t_cls                 q_cls;

    assign o_cfg_ready = 1'b1;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= MOD_WIDTH'(1);
            r_exponent <= EXP_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODULUS:  r_modulus  <= i_cfg_data[MOD_WIDTH-1:0];
                CFG_EXPONENT: r_exponent <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mex_front #(.MOD_WIDTH(MOD_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_base_value,
        .i_modulus(r_modulus), .i_exponent(r_exponent),
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_base(q_base), .o_q_cls(q_cls)
    );

    mex_back #(.MOD_WIDTH(MOD_WIDTH)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_base(q_base), .i_q_cls(q_cls),
        .i_modulus(r_modulus), .i_exponent(r_exponent),
        .o_valid, .i_ready, .o_power_result
    );
endmodule

// ----- sim/modular_exponentiation_signed_exp_tb.sv -----
// Self-checking testbench for the signed-exponent modular exponentiation block
module modular_exponentiation_signed_exp_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mex_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 20000000;
    localparam int unsigned TAIL_CYCLES = 2000;

    typedef enum int {
        IDLE_SEND_LIGHT,
        IDLE_SEND_HEAVY,
        IDLE_NONE
    } t_idle_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [BASE_W-1:0]   i_base_value = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [RES_W-1:0]    o_power_result;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_index = CFG_MODULUS;
    logic [EXP_W-1:0]    i_cfg_data = '0;

    // Shadow registers of the block's configuration
    logic [RES_W-1:0]    cur_modulus = 16'd1;
    logic [EXP_W-1:0]    cur_exponent = 17'd1;

    logic [RES_W-1:0]    expected_powers[$];
    t_idle_mode          idle_mode = IDLE_SEND_LIGHT;
    int unsigned         cycle_count = 0;
    int unsigned         mismatch_count = 0;
    int unsigned         bases_sent = 0;
    int unsigned         results_seen = 0;
    int unsigned         settings_used = 0;

    modular_exponentiation_signed_exp dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_base_value   (i_base_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_power_result (o_power_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Generate the clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // End the run on a hang
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Compute base^exponent mod modulus with signed base and exponent
    function automatic logic [RES_W-1:0] predict_power(logic [BASE_W-1:0] b,
                                                       logic [RES_W-1:0] n,
                                                       logic [EXP_W-1:0] e);
        longint nn, ee, base, mag, res, x, y, s0, s1, s2, q, r;
        nn = n;
        ee = $signed(e);
        base = $signed(b);
        if (ee == 0) return RES_W'(1);
        if (nn == 0) return RES_W'(0);
        base = base % nn;
        if (base < 0) base += nn;
        if (ee < 0) begin
            // Replace base with its Bezout coefficient against the modulus
            x = base;
            y = nn;
            s0 = 1;
            s1 = 0;
            while (y > 0) begin
                q = x / y;
                r = x - q * y;
                s2 = s0 - q * s1;
                x = y;
                y = r;
                s0 = s1;
                s1 = s2;
            end
            base = s0 % nn;
            if (base < 0) base += nn;
            mag = -ee;
        end else begin
            mag = ee;
        end
        res = 1;
        while (mag > 0) begin
            if (mag[0]) res = (res * base) % nn;
            mag = mag >> 1;
            base = (base * base) % nn;
        end
        return res[RES_W-1:0];
    endfunction

    // Randomly stall the result channel according to the idle mode
    always @(posedge i_clk) begin
        case (idle_mode)
            IDLE_SEND_LIGHT: i_ready <= ($urandom_range(99, 0) >= 77);
            IDLE_SEND_HEAVY: i_ready <= ($urandom_range(99, 0) >= 28);
            default:         i_ready <= 1'b1;
        endcase
    end

    // Check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        logic [RES_W-1:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_powers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %0d", o_power_result);
            end else begin
                want = expected_powers.pop_front();
                if (o_power_result !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("power_result mismatch: expected %0d, got %0d",
                                 want, o_power_result);
                end
            end
        end
    end

    // Hold the sender for a random gap, then transfer one base
    task automatic send_base(logic [BASE_W-1:0] b);
        int unsigned gap_pct;
        gap_pct = (idle_mode == IDLE_SEND_LIGHT) ? 28 :
                  (idle_mode == IDLE_SEND_HEAVY) ? 77 : 0;
        if ($urandom_range(99, 0) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99, 0) < gap_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_base_value <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_powers = {expected_powers, predict_power(b, cur_modulus, cur_exponent)};
        bases_sent++;
    endtask

    // Drop valid and wait until every expected result has come
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_powers.size() != 0) @(posedge i_clk);
    endtask

    // Write one configuration register while the block is idle
    task automatic write_config(logic idx, logic [EXP_W-1:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_MODULUS) cur_modulus = data[RES_W-1:0];
        else cur_exponent = data;
    endtask

    task automatic set_config(logic [RES_W-1:0] n, logic [EXP_W-1:0] e);
        write_config(CFG_MODULUS, {1'b0, n});
        write_config(CFG_EXPONENT, e);
        settings_used++;
    endtask

    // Extremes of base, modulus and exponent
    task automatic test_extremes();
        set_config(16'hFFFF, 17'd65535);
        send_base(17'h0FFFF);
        send_base(17'h10000);
        send_base(17'h1FFFF);
        send_base(17'h00000);
        set_config(16'hFFFF, 17'h10001);
        send_base(17'h0FFFF);
        send_base(17'h10000);
        send_base(17'd2);
        set_config(16'd65521, -17'sd3);
        send_base(17'd7);
        send_base(-17'sd7);
    endtask

    // Zero exponent, unit and zero modulus, missing inverse, exponent -65536
    task automatic test_special_cases();
        set_config(16'd1, 17'd0);
        send_base(17'd5);
        send_base(17'h10000);
        set_config(16'd1, 17'd9);
        send_base(17'd12345);
        set_config(16'd0, 17'd3);
        send_base(17'd77);
        set_config(16'd0, -17'sd2);
        send_base(17'd77);
        set_config(16'd12, -17'sd1);
        send_base(17'd4);
        send_base(17'd6);
        send_base(17'd5);
        set_config(16'd257, 17'h10000);
        send_base(17'd3);
        send_base(-17'sd3);
        set_config(16'd3233, 17'd17);
        send_base(17'd65);
        set_config(16'd3233, 17'd2753);
        send_base(17'd2790);
    endtask

    // Random bases over random settings, one set per idle mode
    task automatic test_random();
        logic [RES_W-1:0] n;
        logic [EXP_W-1:0] e;
        int unsigned k;
        for (int m = 0; m < 3; m++) begin
            idle_mode = t_idle_mode'(m);
            for (int s = 0; s < 6; s++) begin
                n = (s == 0) ? 16'hFFFF : (s == 1) ? 16'd1
                                        : RES_W'($urandom_range(65535, 2));
                if (s == 5 && m == 0) e = 17'h10000;
                else if (s == 2) e = EXP_W'($urandom);
                else begin
                    e = EXP_W'($urandom_range(300, 1));
                    if ($urandom_range(1, 0)) e = -e;
                end
                set_config(n, e);
                for (int i = 0; i < 53; i++) begin
                    k = $urandom_range(3, 0);
                    if (k == 0) send_base(BASE_W'($urandom));
                    else send_base(BASE_W'($urandom_range(2 * n, 0) - n));
                    // Hold off once until the pipeline is empty
                    if (m == 2 && s == 3 && i == 20) drain_results();
                end
            end
        end
    endtask

    initial begin
        idle_mode = IDLE_SEND_LIGHT;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_special_cases();
        test_random();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d bases, checked %0d results over %0d register settings",
                 bases_sent, results_seen, settings_used);
        $display("Mismatches: %0d", mismatch_count);
        if (mismatch_count == 0 && expected_powers.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
